### rtl/pool2d_max_avg_stream_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pooling block
// ----------------------------------------------------------------------------
`ifndef POOL2D_MAX_AVG_STREAM_DEFINES_SVH
`define POOL2D_MAX_AVG_STREAM_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PL2D_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PL2D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/pl2d_pkg.sv
// ----------------------------------------------------------------------------
// pl2d_pkg
// Shared types, register codes and helpers of the 2D pooling block.
// ----------------------------------------------------------------------------
package pl2d_pkg;

    localparam int SAMPLE_W = 16;
    localparam int K_W      = 4;
    localparam int PH_W     = 16;
    localparam int PW_W     = 11;
    localparam int AREA_W   = 8;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic MODE_AVG = 1'b0;
    localparam logic MODE_MAX = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KERNEL_HEIGHT = 3'd0,
        CFG_KERNEL_WIDTH  = 3'd1,
        CFG_STRIDE_ROWS   = 3'd2,
        CFG_STRIDE_COLS   = 3'd3,
        CFG_PLANE_HEIGHT  = 3'd4,
        CFG_PLANE_WIDTH   = 3'd5,
        CFG_POOL_MODE     = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [K_W-1:0]  kernel_height;
        logic [K_W-1:0]  kernel_width;
        logic [K_W-1:0]  stride_rows;
        logic [K_W-1:0]  stride_cols;
        logic [PH_W-1:0] plane_height;
        logic [PW_W-1:0] plane_width;
        logic            pool_mode;
    } t_cfg;

    typedef enum logic [1:0] {
        F_RUN,
        F_PEND,
        F_ROW,
        F_COL
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SCAN,
        B_DRAIN,
        B_DIV_GO,
        B_DIV_WAIT,
        B_OUT
    } t_back_state;

    // Zero counts as one.
    function automatic logic [K_W-1:0] nz4(input logic [K_W-1:0] v);
        return (v == '0) ? K_W'(1) : v;
    endfunction

    // Zero counts as one, above the limit saturates.
    function automatic logic [K_W-1:0] clamp_kernel(input logic [K_W-1:0] v,
                                                    input logic [K_W:0] hi);
        logic [K_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = K_W'(1);
        end else if ({1'b0, v} > hi) begin
            res = hi[K_W-1:0];
        end
        return res;
    endfunction

    // Advance a stride phase, wrapping at the stride.
    function automatic logic [K_W-1:0] next_phase(input logic [K_W-1:0] ph,
                                                  input logic [K_W-1:0] s);
        return (ph + K_W'(1) == s) ? '0 : ph + K_W'(1);
    endfunction

endpackage

### rtl/pl2d_fifo.sv
// ----------------------------------------------------------------------------
// pl2d_fifo
// Small job queue between the classifying front and the pooling back.
// ----------------------------------------------------------------------------
module pl2d_fifo #(
    parameter int DW    = 8,
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    input  logic          i_pop,
    output logic [DW-1:0] o_data,
    output logic          o_full,
    output logic          o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DW-1:0] r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ptr_inc(r_wp);
            end
            if (i_pop) begin
                r_rp <= ptr_inc(r_rp);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (PW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - (PW+1)'(1);
            end
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);

endmodule

### rtl/pl2d_front.sv
// ----------------------------------------------------------------------------
// pl2d_front
// Tracks raster position and stride phases, classifies each word.
// ----------------------------------------------------------------------------
module pl2d_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_KERNEL = 8,
    parameter int CW         = 10,
    parameter int KB         = 3
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  pl2d_pkg::t_cfg         i_cfg,
    input  logic                   i_cfg_we,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic signed [15:0]     i_sample,
    input  logic                   i_full,
    output logic                   o_push,
    output logic signed [15:0]     o_sample,
    output logic [KB-1:0]          o_slot,
    output logic [CW-1:0]          o_col,
    output logic                   o_win,
    output logic                   o_done
);

    pl2d_pkg::t_front_state r_state, n_state;

    logic [15:0]   r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [KB-1:0] r_slot, n_slot;
    logic [3:0]    r_rph, n_rph;
    logic [3:0]    r_cph, n_cph;
    logic [15:0]   r_mx;
    logic [3:0]    r_rem;
    logic [4:0]    r_it;

    logic [3:0]  kh, kw, sh, sw;
    logic [15:0] h;
    logic [13:0] w;
    logic [16:0] r1, rn1;
    logic [13:0] c1, cn1;
    logic        accept, wrap_row;
    logic [3:0]  div;
    logic [4:0]  rem_sh;
    logic [3:0]  rem_nx;
    logic [15:0] row_x, col_x;

    always_comb begin
        kh = pl2d_pkg::clamp_kernel(i_cfg.kernel_height, 5'(MAX_KERNEL));
        kw = pl2d_pkg::clamp_kernel(i_cfg.kernel_width, 5'(MAX_KERNEL));
        sh = pl2d_pkg::nz4(i_cfg.stride_rows);
        sw = pl2d_pkg::nz4(i_cfg.stride_cols);
        h  = (i_cfg.plane_height == '0) ? 16'd1 : i_cfg.plane_height;
        if (i_cfg.plane_width == '0) begin
            w = 14'd1;
        end else if ({3'b0, i_cfg.plane_width} > 14'(MAX_WIDTH)) begin
            w = 14'(MAX_WIDTH);
        end else begin
            w = {3'b0, i_cfg.plane_width};
        end
    end

    // Next-state logic
    always_comb begin
        n_state = r_state;
        if (i_cfg_we) begin
            n_state = pl2d_pkg::F_PEND;
        end else begin
            unique case (r_state)
                pl2d_pkg::F_RUN:  n_state = pl2d_pkg::F_RUN;
                pl2d_pkg::F_PEND: n_state = pl2d_pkg::F_ROW;
                pl2d_pkg::F_ROW:  n_state = (r_it == 5'd1) ? pl2d_pkg::F_COL
                                                           : pl2d_pkg::F_ROW;
                pl2d_pkg::F_COL:  n_state = (r_it == 5'd1) ? pl2d_pkg::F_RUN
                                                           : pl2d_pkg::F_COL;
                default:          n_state = pl2d_pkg::F_RUN;
            endcase
        end
    end

    // Output logic
    always_comb begin
        o_ready = 1'b0;
        unique case (r_state)
            pl2d_pkg::F_RUN: o_ready = !i_cfg_we && !i_full;
            default:         o_ready = 1'b0;
        endcase
    end

    assign accept = i_valid && o_ready;

    // Position and phase advance
    always_comb begin
        r1  = {1'b0, r_row} + 17'd1;
        c1  = 14'(r_col) + 14'd1;
        cn1 = c1 + 14'd1;
        n_row  = r_row;
        n_col  = r_col;
        n_slot = r_slot;
        n_rph  = r_rph;
        n_cph  = r_cph;
        wrap_row = (r1 >= {1'b0, h});
        rn1 = 17'd1;
        if (c1 >= w) begin
            n_col = '0;
            n_cph = '0;
            if (wrap_row) begin
                n_row  = '0;
                n_slot = '0;
            end else begin
                n_row  = r1[15:0];
                n_slot = (r_slot == KB'(MAX_KERNEL - 1)) ? '0 : r_slot + KB'(1);
            end
            rn1 = {1'b0, n_row} + 17'd1;
            if (rn1 == 17'(kh)) begin
                n_rph = '0;
            end else if (rn1 > 17'(kh)) begin
                n_rph = pl2d_pkg::next_phase(r_rph, sh);
            end
        end else begin
            n_col = c1[CW-1:0];
            if (cn1 == 14'(kw)) begin
                n_cph = '0;
            end else if (cn1 > 14'(kw)) begin
                n_cph = pl2d_pkg::next_phase(r_cph, sw);
            end
        end
    end

    // Phase recompute: one remainder bit per cycle
    always_comb begin
        div    = (r_state == pl2d_pkg::F_ROW) ? sh : sw;
        rem_sh = {r_rem, r_mx[15]};
        rem_nx = (rem_sh >= {1'b0, div}) ? 4'(rem_sh - {1'b0, div}) : rem_sh[3:0];
        row_x  = (r1 >= 17'(kh)) ? 16'(r1 - 17'(kh)) : 16'd0;
        col_x  = (c1 >= 14'(kw)) ? 16'(c1 - 14'(kw)) : 16'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pl2d_pkg::F_RUN;
            r_row   <= '0;
            r_col   <= '0;
            r_slot  <= '0;
            r_rph   <= '0;
            r_cph   <= '0;
            r_mx    <= '0;
            r_rem   <= '0;
            r_it    <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_row  <= n_row;
                r_col  <= n_col;
                r_slot <= n_slot;
                r_rph  <= n_rph;
                r_cph  <= n_cph;
            end
            case (r_state)
                pl2d_pkg::F_PEND: begin
                    r_mx  <= row_x;
                    r_rem <= '0;
                    r_it  <= 5'd16;
                end
                pl2d_pkg::F_ROW: begin
                    if (r_it == 5'd1) begin
                        r_rph <= rem_nx;
                        r_mx  <= col_x;
                        r_rem <= '0;
                        r_it  <= 5'd16;
                    end else begin
                        r_mx  <= {r_mx[14:0], 1'b0};
                        r_rem <= rem_nx;
                        r_it  <= r_it - 5'd1;
                    end
                end
                pl2d_pkg::F_COL: begin
                    r_mx  <= {r_mx[14:0], 1'b0};
                    r_rem <= rem_nx;
                    r_it  <= r_it - 5'd1;
                    if (r_it == 5'd1) begin
                        r_cph <= rem_nx;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_push   = accept;
    assign o_sample = i_sample;
    assign o_slot   = r_slot;
    assign o_col    = r_col;
    assign o_win    = (r_row < h) && (14'(r_col) < w) && (r1 >= 17'(kh))
                      && (c1 >= 14'(kw)) && (r_rph == '0) && (r_cph == '0);
    assign o_done   = (17'(r_row) + 17'(sh) >= 17'(h))
                      && (14'(r_col) + 14'(sw) >= w);

endmodule

### rtl/pl2d_div.sv
// ----------------------------------------------------------------------------
// pl2d_div
// Signed by unsigned divider, one quotient bit per cycle, truncates to zero.
// ----------------------------------------------------------------------------
module pl2d_div #(
    parameter int SW = 22
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [SW-1:0]              i_dividend,
    input  logic [pl2d_pkg::AREA_W-1:0]       i_divisor,
    output logic                              o_done,
    output logic signed [15:0]                o_quotient
);

    localparam int AW = pl2d_pkg::AREA_W;
    localparam int NW = $clog2(SW + 1);

    logic          r_busy;
    logic [NW-1:0] r_cnt;
    logic [SW-1:0] r_mag;
    logic [AW-1:0] r_rem;
    logic [AW-1:0] r_div;
    logic          r_neg;
    logic          r_done;
    logic signed [15:0] r_q;

    logic [AW:0]   rem_sh;
    logic          ge;
    logic [AW-1:0] rem_nx;
    logic [SW-1:0] q_full;

    always_comb begin
        rem_sh = {r_rem, r_mag[SW-1]};
        ge     = (rem_sh >= {1'b0, r_div});
        rem_nx = ge ? AW'(rem_sh - {1'b0, r_div}) : rem_sh[AW-1:0];
        q_full = {r_mag[SW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= NW'(SW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - NW'(1);
                if (r_cnt == NW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SW-1];
            r_mag <= i_dividend[SW-1] ? SW'(-i_dividend) : SW'(i_dividend);
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_mag <= q_full;
            r_rem <= rem_nx;
            if (r_cnt == NW'(1)) begin
                r_q <= r_neg ? -16'(q_full) : 16'(q_full);
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

### rtl/pl2d_back.sv
// ----------------------------------------------------------------------------
// pl2d_back
// Line store, window scan one column per cycle, max or average, result reg.
// ----------------------------------------------------------------------------
module pl2d_back #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_KERNEL = 8,
    parameter int CW         = 10,
    parameter int KB         = 3,
    parameter int SW         = 22
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pl2d_pkg::t_cfg     i_cfg,
    input  logic               i_empty,
    output logic               o_pop,
    input  logic signed [15:0] i_sample,
    input  logic [KB-1:0]      i_slot,
    input  logic [CW-1:0]      i_col,
    input  logic               i_win,
    input  logic               i_done,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_pooled_value,
    output logic               o_plane_done
);

    pl2d_pkg::t_back_state r_state, n_state;

    logic [KB-1:0]        r_slot;
    logic [CW-1:0]        r_addr;
    logic [3:0]           r_cnt;
    logic signed [SW-1:0] r_acc;
    logic                 r_rd_vld;
    logic signed [15:0]   r_rd [MAX_KERNEL];
    logic                 r_pdone;
    logic                 r_ovld;
    logic signed [15:0]   r_opv;
    logic                 r_odone;

    logic [3:0]           kh, kw;
    logic [pl2d_pkg::AREA_W-1:0] area;
    logic                 out_free;
    logic                 scan, div_go, load_out;
    logic signed [SW-1:0] cmb_max, cmb_sum;
    logic [4:0]           row_off;
    logic                 div_done;
    logic signed [15:0]   div_q;

    assign kh   = pl2d_pkg::clamp_kernel(i_cfg.kernel_height, 5'(MAX_KERNEL));
    assign kw   = pl2d_pkg::clamp_kernel(i_cfg.kernel_width, 5'(MAX_KERNEL));
    assign area = pl2d_pkg::AREA_W'(kh) * pl2d_pkg::AREA_W'(kw);
    assign out_free = !r_ovld || i_ready;

    // Line store: one bank per row slot, all banks read the same column
    for (genvar b = 0; b < MAX_KERNEL; b++) begin : g_bank
        logic [15:0] bank [MAX_WIDTH];
        always_ff @(posedge i_clk) begin
            if (o_pop && (i_slot == KB'(b))) begin
                bank[i_col] <= i_sample;
            end
            if (scan) begin
                r_rd[b] <= bank[r_addr];
            end
        end
    end

    // Next-state logic
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pl2d_pkg::B_IDLE:     if (!i_empty && i_win) n_state = pl2d_pkg::B_SCAN;
            pl2d_pkg::B_SCAN:     if (r_cnt == 4'd1) n_state = pl2d_pkg::B_DRAIN;
            pl2d_pkg::B_DRAIN:    n_state = (i_cfg.pool_mode == pl2d_pkg::MODE_MAX)
                                            ? pl2d_pkg::B_OUT : pl2d_pkg::B_DIV_GO;
            pl2d_pkg::B_DIV_GO:   n_state = pl2d_pkg::B_DIV_WAIT;
            pl2d_pkg::B_DIV_WAIT: if (div_done) n_state = pl2d_pkg::B_OUT;
            pl2d_pkg::B_OUT:      if (out_free) n_state = pl2d_pkg::B_IDLE;
            default:              n_state = pl2d_pkg::B_IDLE;
        endcase
    end

    // Output logic
    always_comb begin
        o_pop    = 1'b0;
        scan     = 1'b0;
        div_go   = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            pl2d_pkg::B_IDLE:   o_pop    = !i_empty;
            pl2d_pkg::B_SCAN:   scan     = 1'b1;
            pl2d_pkg::B_DIV_GO: div_go   = 1'b1;
            pl2d_pkg::B_OUT:    load_out = out_free;
            default: begin
            end
        endcase
    end

    // Fold one column of the window into the running value
    always_comb begin
        cmb_max = r_acc;
        cmb_sum = r_acc;
        row_off = '0;
        for (int b = 0; b < MAX_KERNEL; b++) begin
            if (5'(r_slot) >= 5'(b)) begin
                row_off = 5'(r_slot) - 5'(b);
            end else begin
                row_off = 5'(r_slot) + 5'(MAX_KERNEL) - 5'(b);
            end
            if (row_off < {1'b0, kh}) begin
                if (SW'(r_rd[b]) > cmb_max) begin
                    cmb_max = SW'(r_rd[b]);
                end
                cmb_sum = cmb_sum + SW'(r_rd[b]);
            end
        end
    end

    pl2d_div #(
        .SW(SW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_go),
        .i_dividend (r_acc),
        .i_divisor  (area),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pl2d_pkg::B_IDLE;
            r_rd_vld <= 1'b0;
            r_ovld   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= scan;
            if (load_out) begin
                r_ovld <= 1'b1;
            end else if (i_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_win) begin
            r_slot  <= i_slot;
            r_addr  <= i_col - CW'(kw - 4'd1);
            r_cnt   <= kw;
            r_pdone <= i_done;
            r_acc   <= (i_cfg.pool_mode == pl2d_pkg::MODE_MAX)
                       ? SW'(-32768) : '0;
        end else begin
            if (scan) begin
                r_addr <= r_addr + CW'(1);
                r_cnt  <= r_cnt - 4'd1;
            end
            if (r_rd_vld) begin
                r_acc <= (i_cfg.pool_mode == pl2d_pkg::MODE_MAX) ? cmb_max : cmb_sum;
            end
        end
        if (load_out) begin
            r_opv   <= (i_cfg.pool_mode == pl2d_pkg::MODE_MAX) ? r_acc[15:0] : div_q;
            r_odone <= r_pdone;
        end
    end

    assign o_valid        = r_ovld;
    assign o_pooled_value = r_opv;
    assign o_plane_done   = r_odone;

endmodule

### rtl/pool2d_max_avg_stream.sv
// ----------------------------------------------------------------------------
// pool2d_max_avg_stream
// Streaming 2D max / average pooling of signed Q8.8 planes in raster order.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  --------+----------------------------+--------------------------------
//  in      | i_in_valid / o_in_ready    | i_sample
//  out     | o_out_valid / i_out_ready  | o_pooled_value, o_plane_done
//  config  | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// A word that closes no window is popped while the back end stays idle.
// A window is scanned column by column, then drained; average mode adds
// the bit-serial divider before the result register is loaded.
// Every config write blocks input while the stride phases are
// recomputed. Reset is synchronous; the line store is not cleared.
// A four-entry job queue lets the front keep taking words while the back
// scans a window or waits on a stalled result.
// ----------------------------------------------------------------------------
module pool2d_max_avg_stream #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_KERNEL = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [15:0]                  i_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [15:0]                  o_pooled_value,
    output logic                                o_plane_done,
    input  logic                                i_cfg_we,
    input  logic [pl2d_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pl2d_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int KB = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int SW = 16 + $clog2(MAX_KERNEL * MAX_KERNEL);
    localparam int JW = 16 + KB + CW + 2;

    pl2d_pkg::t_cfg r_cfg;

    logic               push, pop, full, empty;
    logic signed [15:0] f_sample, b_sample;
    logic [KB-1:0]      f_slot, b_slot;
    logic [CW-1:0]      f_col, b_col;
    logic               f_win, f_done, b_win, b_done;
    logic [JW-1:0]      q_in, q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kernel_height <= 4'd2;
            r_cfg.kernel_width  <= 4'd2;
            r_cfg.stride_rows   <= 4'd2;
            r_cfg.stride_cols   <= 4'd2;
            r_cfg.plane_height  <= 16'd32;
            r_cfg.plane_width   <= 11'd32;
            r_cfg.pool_mode     <= pl2d_pkg::MODE_MAX;
        end else if (i_cfg_we) begin
            unique case (pl2d_pkg::t_cfg_idx'(i_cfg_idx))
                pl2d_pkg::CFG_KERNEL_HEIGHT: r_cfg.kernel_height <= i_cfg_data[3:0];
                pl2d_pkg::CFG_KERNEL_WIDTH:  r_cfg.kernel_width  <= i_cfg_data[3:0];
                pl2d_pkg::CFG_STRIDE_ROWS:   r_cfg.stride_rows   <= i_cfg_data[3:0];
                pl2d_pkg::CFG_STRIDE_COLS:   r_cfg.stride_cols   <= i_cfg_data[3:0];
                pl2d_pkg::CFG_PLANE_HEIGHT:  r_cfg.plane_height  <= i_cfg_data;
                pl2d_pkg::CFG_PLANE_WIDTH:   r_cfg.plane_width   <= i_cfg_data[10:0];
                pl2d_pkg::CFG_POOL_MODE:     r_cfg.pool_mode     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    pl2d_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_KERNEL(MAX_KERNEL),
        .CW        (CW),
        .KB        (KB)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_cfg_we (i_cfg_we),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_sample (i_sample),
        .i_full   (full),
        .o_push   (push),
        .o_sample (f_sample),
        .o_slot   (f_slot),
        .o_col    (f_col),
        .o_win    (f_win),
        .o_done   (f_done)
    );

    assign q_in = {f_sample, f_slot, f_col, f_win, f_done};
    assign {b_sample, b_slot, b_col, b_win, b_done} = q_out;

    pl2d_fifo #(
        .DW   (JW),
        .DEPTH(4)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (q_in),
        .i_pop  (pop),
        .o_data (q_out),
        .o_full (full),
        .o_empty(empty)
    );

    pl2d_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_KERNEL(MAX_KERNEL),
        .CW        (CW),
        .KB        (KB),
        .SW        (SW)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_empty        (empty),
        .o_pop          (pop),
        .i_sample       (b_sample),
        .i_slot         (b_slot),
        .i_col          (b_col),
        .i_win          (b_win),
        .i_done         (b_done),
        .o_valid        (o_out_valid),
        .i_ready        (i_out_ready),
        .o_pooled_value (o_pooled_value),
        .o_plane_done   (o_plane_done)
    );

endmodule

### rtl/pool2d_max_avg_stream_chk.sv
// ----------------------------------------------------------------------------
// pool2d_max_avg_stream_chk
// Port-level checks of the pooling block, bound to the top level.
// ----------------------------------------------------------------------------
`include "pool2d_max_avg_stream_defines.svh"

module pool2d_max_avg_stream_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic signed [15:0]             o_pooled_value,
    input logic                           o_plane_done,
    input logic                           i_cfg_we
);

    // Hold a stalled result word
    `PL2D_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_pooled_value) && $stable(o_plane_done), "result word changed while stalled")

    // No word is taken in the cycle of a config write
    `PL2D_ASSERT_SAME(a_cfg_block, i_clk, i_rst_n, i_cfg_we, !o_in_ready, "input ready during config write")

    // Phase recompute keeps input closed right after a config write
    `PL2D_ASSERT_NEXT(a_cfg_resync, i_clk, i_rst_n, i_cfg_we, !o_in_ready, "input ready right after config write")

endmodule

bind pool2d_max_avg_stream pool2d_max_avg_stream_chk u_chk (.*);
